/* rtl/core/slcc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes, tables and helpers of the status LED command controller.
package slcc_pkg;

  // LED / shown state codes
  typedef enum logic [2:0] {
    LED_IDLE      = 3'd0,
    LED_READY     = 3'd1,
    LED_RECORDING = 3'd2,
    LED_SPEAKING  = 3'd3,
    LED_ERROR     = 3'd4,
    LED_UNKNOWN   = 3'd5
  } led_code_t;

  // Line parser phases
  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_P1     = 3'd1,
    PH_P2     = 3'd2,
    PH_P3     = 3'd3,
    PH_P4     = 3'd4,
    PH_SPACE  = 3'd5,
    PH_REST   = 3'd6,
    PH_REJECT = 3'd7
  } line_phase_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE  = 2'd0;
  localparam logic [1:0] CFG_HEARTBEAT = 2'd1;
  localparam logic [1:0] CFG_MAX_LINE  = 2'd2;

  // Item kinds on tuser
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  localparam logic [7:0]  DEBOUNCE_RESET  = 8'd35;
  localparam logic [15:0] HEARTBEAT_RESET = 16'd5000;
  localparam logic [7:0]  MAX_LINE_RESET  = 8'd79;
  localparam logic [16:0] HB_MAX          = 17'h1FFFF;
  localparam logic [7:0]  QUIET_MAX       = 8'hFF;
  localparam logic [7:0]  CHAR_NEWLINE    = 8'h0A;
  localparam logic [7:0]  CHAR_SPACE      = 8'h20;

  // "STATE", indexed by parser phase
  localparam logic [7:0] PREFIX_TEXT [8] = '{
    8'h53, 8'h54, 8'h41, 8'h54, 8'h45, 8'h00, 8'h00, 8'h00
  };

  // ready, recording, speaking, error; zero padded to 16 positions
  localparam logic [7:0] WORD_TEXT [4][16] = '{
    '{8'h72, 8'h65, 8'h61, 8'h64, 8'h79, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h72, 8'h65, 8'h63, 8'h6F, 8'h72, 8'h64, 8'h69, 8'h6E,
      8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h73, 8'h70, 8'h65, 8'h61, 8'h6B, 8'h69, 8'h6E, 8'h67,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h65, 8'h72, 8'h72, 8'h6F, 8'h72, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] WORD_LEN [4] = '{4'd5, 4'd9, 4'd8, 4'd5};

  // Result of a finished line
  typedef struct packed {
    logic      hit;
    led_code_t code;
  } line_result_t;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == CHAR_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // {red, green, blue}
  function automatic logic [23:0] led_colour(input led_code_t code);
    unique case (code)
      LED_IDLE:      led_colour = {8'd8,  8'd8,  8'd8};
      LED_READY:     led_colour = {8'd0,  8'd32, 8'd0};
      LED_RECORDING: led_colour = {8'd40, 8'd0,  8'd0};
      LED_SPEAKING:  led_colour = {8'd0,  8'd24, 8'd32};
      LED_ERROR:     led_colour = {8'd40, 8'd0,  8'd40};
      default:       led_colour = {8'd32, 8'd20, 8'd0};
    endcase
  endfunction

endpackage

/* rtl/core/slcc_line_parser.sv */
`timescale 1ns / 1ps
// Serial line collector and "STATE <word>" matcher.
module slcc_line_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  input  logic [7:0]            max_line_length,
  output slcc_pkg::line_result_t result
);
  import slcc_pkg::*;

  logic [7:0]  line_length, line_length_next;
  line_phase_t line_phase, line_phase_next;
  logic [3:0]  word_candidates, word_candidates_next;
  logic [3:0]  word_position, word_position_next;
  logic        pending_space, pending_space_next;
  logic        rest_nonempty, rest_nonempty_next;

  logic        ws;
  logic        newline;
  logic [3:0]  char_match;

  assign ws      = is_ws(rx_byte);
  assign newline = (rx_byte == CHAR_NEWLINE);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      char_match[i] = (word_position < WORD_LEN[i]) &&
                      (WORD_TEXT[i][word_position] == rx_byte);
    end
  end

  // Next state
  always_comb begin
    line_length_next     = line_length;
    line_phase_next      = line_phase;
    word_candidates_next = word_candidates;
    word_position_next   = word_position;
    pending_space_next   = pending_space;
    rest_nonempty_next   = rest_nonempty;
    if (newline || (line_length >= max_line_length)) begin
      // end of line, or overflow: start over
      line_length_next     = '0;
      line_phase_next      = PH_LEAD;
      word_candidates_next = '1;
      word_position_next   = '0;
      pending_space_next   = 1'b0;
      rest_nonempty_next   = 1'b0;
    end else begin
      line_length_next = line_length + 8'd1;
      unique case (line_phase)
        PH_LEAD: begin
          if (!ws) begin
            line_phase_next = (rx_byte == PREFIX_TEXT[0]) ? PH_P1 : PH_REJECT;
          end
        end
        PH_P1, PH_P2, PH_P3, PH_P4: begin
          line_phase_next = (rx_byte == PREFIX_TEXT[line_phase]) ?
                            line_phase_t'(line_phase + 3'd1) : PH_REJECT;
        end
        PH_SPACE: begin
          line_phase_next = (rx_byte == CHAR_SPACE) ? PH_REST : PH_REJECT;
        end
        PH_REST: begin
          if (ws) begin
            pending_space_next = 1'b1;
          end else begin
            if (pending_space) begin
              word_candidates_next = '0;
            end else begin
              word_candidates_next = word_candidates & char_match;
              if (word_position != 4'hF) begin
                word_position_next = word_position + 4'd1;
              end
            end
            rest_nonempty_next = 1'b1;
            pending_space_next = 1'b0;
          end
        end
        PH_REJECT: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Outputs: verdict on newline, first matching word wins
  always_comb begin
    result.hit  = newline && (line_phase == PH_REST) && rest_nonempty;
    result.code = LED_UNKNOWN;
    for (int i = 3; i >= 0; i--) begin
      if (word_candidates[i] && (word_position == WORD_LEN[i])) begin
        result.code = led_code_t'(3'(i + 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length     <= '0;
      line_phase      <= PH_LEAD;
      word_candidates <= '1;
      word_position   <= '0;
      pending_space   <= 1'b0;
      rest_nonempty   <= 1'b0;
    end else if (step) begin
      line_length     <= line_length_next;
      line_phase      <= line_phase_next;
      word_candidates <= word_candidates_next;
      word_position   <= word_position_next;
      pending_space   <= pending_space_next;
      rest_nonempty   <= rest_nonempty_next;
    end
  end

endmodule

/* rtl/core/status_led_command_controller.sv */
`timescale 1ns / 1ps
// Status LED command controller: button debounce, heartbeat and serial state lines.
//
//  Channel  Direction  Handshake                    Contents
//  s_axis   in         s_axis_tvalid/s_axis_tready  tick (button sample) or serial byte
//  m_axis   out        m_axis_tvalid/m_axis_tready  press flag, shown state, LED colour
//  cfg      in         cfg_we (no wait)             debounce, heartbeat timeout, line limit
//
// Each transfer in gives exactly one transfer out. The item sits in an input register, is
// worked through combinationally and lands in the output register: one item per cycle
// sustained while the output is not stalled.
// rst is synchronous: counters, matcher, LED code and config (35 / 5000 / 79) to reset values.
// A stalled output holds its result; the input register still takes one more item, then
// s_axis_tready follows m_axis_tready.
module status_led_command_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [0] button_level, [8:1] rx_byte, [15:9] zero
  input  logic        s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [0] press, [3:1] shown_state, [11:4] led_red,
                                      // [19:12] led_green, [27:20] led_blue, [31:28] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import slcc_pkg::*;

  // configuration
  logic [7:0]  debounce_ms;
  logic [15:0] heartbeat_timeout_ms;
  logic [7:0]  max_line_length;

  // input register
  logic        in_valid;
  logic        in_command;
  logic        in_level;
  logic [7:0]  in_byte;

  // block state
  logic        last_level, last_level_next;
  logic        stable_level, stable_level_next;
  logic [7:0]  quiet_ticks, quiet_ticks_next;
  logic [16:0] since_heartbeat, since_heartbeat_next;
  led_code_t   led_code, led_code_next;

  // output register
  logic        out_valid;
  logic [31:0] out_data;

  logic         advance;
  logic         in_take;
  logic         press;
  logic         byte_step;
  line_result_t line_res;
  logic [23:0]  rgb;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign byte_step     = advance && (in_command == CMD_BYTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms          <= DEBOUNCE_RESET;
      heartbeat_timeout_ms <= HEARTBEAT_RESET;
      max_line_length      <= MAX_LINE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:  debounce_ms          <= cfg_data[7:0];
        CFG_HEARTBEAT: heartbeat_timeout_ms <= cfg_data;
        CFG_MAX_LINE:  max_line_length      <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_command <= s_axis_tuser;
      in_level   <= s_axis_tdata[0];
      in_byte    <= s_axis_tdata[8:1];
    end
  end

  slcc_line_parser u_line (
    .clk             (clk),
    .rst             (rst),
    .step            (byte_step),
    .rx_byte         (in_byte),
    .max_line_length (max_line_length),
    .result          (line_res)
  );

  always_comb begin
    last_level_next      = last_level;
    stable_level_next    = stable_level;
    quiet_ticks_next     = quiet_ticks;
    since_heartbeat_next = since_heartbeat;
    led_code_next        = led_code;
    press                = 1'b0;
    if (in_command == CMD_TICK) begin
      if (since_heartbeat != HB_MAX) begin
        since_heartbeat_next = since_heartbeat + 17'd1;
      end
      if (in_level != last_level) begin
        last_level_next  = in_level;
        quiet_ticks_next = '0;
      end else if (quiet_ticks != QUIET_MAX) begin
        quiet_ticks_next = quiet_ticks + 8'd1;
      end
      // level held long enough: becomes stable; a fall is a press
      if ((quiet_ticks_next >= debounce_ms) && (in_level != stable_level)) begin
        stable_level_next = in_level;
        press             = !in_level;
      end
    end else if (line_res.hit) begin
      led_code_next        = line_res.code;
      since_heartbeat_next = '0;
    end
    // heartbeat lost: back to dim white
    if (since_heartbeat_next > {1'b0, heartbeat_timeout_ms}) begin
      led_code_next = LED_IDLE;
    end
  end

  assign rgb = led_colour(led_code_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level      <= 1'b1;
      stable_level    <= 1'b1;
      quiet_ticks     <= '0;
      since_heartbeat <= '0;
      led_code        <= LED_IDLE;
    end else if (advance) begin
      last_level      <= last_level_next;
      stable_level    <= stable_level_next;
      quiet_ticks     <= quiet_ticks_next;
      since_heartbeat <= since_heartbeat_next;
      led_code        <= led_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {4'd0, rgb[7:0], rgb[15:8], rgb[23:16], led_code_next, press};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

/* rtl/core/slcc_checker.sv */
`timescale 1ns / 1ps
// Port-level checker of the status LED command controller, with its bind.
module slcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  import slcc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid straight after reset");

  // shown state stays within its codes and the padding stays clear
  a_state_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[3:1] <= LED_UNKNOWN) && (m_axis_tdata[31:28] == 4'd0))
    else $error("shown state out of range");

  // colour always matches the shown state
  a_colour: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      {m_axis_tdata[11:4], m_axis_tdata[19:12], m_axis_tdata[27:20]} ==
      led_colour(led_code_t'(m_axis_tdata[3:1])))
    else $error("colour does not match shown state");

endmodule

bind status_led_command_controller slcc_checker u_slcc_checker (.*);

/* sim/status_led_command_controller_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the status LED command controller, with its own line and debounce predictor.
module status_led_command_controller_test;
  import slcc_pkg::*;

  // Generous: about 900 transfers, each with random gaps on both sides.
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 30;

  // Colour per shown state as {red, green, blue}; codes above unknown show amber too.
  localparam logic [23:0] LED_RGB [8] = '{
    24'h080808, 24'h002000, 24'h280000, 24'h001820,
    24'h280028, 24'h201400, 24'h201400, 24'h201400
  };

  typedef struct packed {
    logic       press;
    logic [2:0] shown;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } led_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;     // [0] button_level, [8:1] rx_byte, [15:9] zero
  logic        s_axis_tuser = CMD_TICK; // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // [0] press, [3:1] shown_state, [11:4] red,
                                      // [19:12] green, [27:20] blue, [31:28] zero
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_DEBOUNCE;
  logic [15:0] cfg_data = '0;

  // Text the line matcher looks for
  string state_tag = "STATE";
  string word_names [4] = '{"ready", "recording", "speaking", "error"};

  // Predictor configuration, follows every register write
  int cfg_debounce = DEBOUNCE_RESET;
  int cfg_timeout  = HEARTBEAT_RESET;
  int cfg_line_max = MAX_LINE_RESET;

  // Predictor state
  logic        btn_prev = 1'b1;
  logic        btn_stable = 1'b1;
  logic [7:0]  btn_quiet = '0;
  logic [16:0] hb_age = '0;
  logic [7:0]  ln_len = '0;
  line_phase_t ln_phase = PH_LEAD;
  logic [3:0]  ln_words = 4'hF;
  logic [3:0]  ln_pos = '0;
  logic        ln_gap = 1'b0;
  logic        ln_has_rest = 1'b0;
  led_code_t   led = LED_IDLE;

  led_report_t pending_reports [$];

  // Bookkeeping
  bit steady = 1'b0;      // no idling on either side while set
  logic cur_level = 1'b1; // button level held by ticks sent inside lines
  int items_sent = 0;
  int results_checked = 0;
  int presses_seen = 0;
  int state_lines = 0;
  int stale_drops = 0;
  int error_count = 0;
  int cycle_count = 0;

  always #2 clk = ~clk;

  status_led_command_controller i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Space, tab, LF, VT, FF, CR count as blanks for trimming
  function automatic logic blank_char(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic void clear_line();
    ln_len      = '0;
    ln_phase    = PH_LEAD;
    ln_words    = 4'hF;
    ln_pos      = '0;
    ln_gap      = 1'b0;
    ln_has_rest = 1'b0;
  endfunction

  // One kept byte through the matcher: leading blanks, "STATE", one space, then the word
  function automatic void take_char(input logic [7:0] c);
    logic sp;
    sp = blank_char(c);
    case (ln_phase)
      PH_LEAD: begin
        if (!sp) ln_phase = (c == state_tag[0]) ? PH_P1 : PH_REJECT;
      end
      PH_P1, PH_P2, PH_P3, PH_P4: begin
        ln_phase = (c == state_tag[int'(ln_phase)]) ? line_phase_t'(ln_phase + 3'd1)
                                                    : PH_REJECT;
      end
      PH_SPACE: begin
        ln_phase = (c == CHAR_SPACE) ? PH_REST : PH_REJECT;
      end
      PH_REST: begin
        if (sp) begin
          ln_gap = 1'b1;
        end else begin
          // a blank followed by more text kills every word
          if (ln_gap) begin
            ln_words = '0;
          end else begin
            for (int i = 0; i < 4; i++) begin
              if (ln_pos >= word_names[i].len() || word_names[i][ln_pos] != c)
                ln_words[i] = 1'b0;
            end
            if (ln_pos != 4'hF) ln_pos = ln_pos + 4'd1;
          end
          ln_has_rest = 1'b1;
          ln_gap      = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  // Newline: a state line with a nonempty rest picks the colour and restarts the heartbeat
  function automatic void finish_line();
    led_code_t code;
    bit found;
    if (ln_phase == PH_REST && ln_has_rest) begin
      code  = LED_UNKNOWN;
      found = 1'b0;
      for (int i = 0; i < 4; i++) begin
        if (!found && ln_words[i] && ln_pos == word_names[i].len()) begin
          code  = led_code_t'(i + 1);
          found = 1'b1;
        end
      end
      led    = code;
      hb_age = '0;
      state_lines++;
    end
    clear_line();
  endfunction

  function automatic led_report_t predict_led(input logic cmd, input logic lvl,
                                              input logic [7:0] ch);
    led_report_t r;
    logic [23:0] rgb;
    r.press = 1'b0;
    if (cmd == CMD_TICK) begin
      if (hb_age != HB_MAX) hb_age = hb_age + 17'd1;
      if (lvl != btn_prev) begin
        btn_prev  = lvl;
        btn_quiet = '0;
      end else if (btn_quiet != QUIET_MAX) begin
        btn_quiet = btn_quiet + 8'd1;
      end
      if (btn_quiet >= cfg_debounce && lvl != btn_stable) begin
        btn_stable = lvl;
        r.press    = (lvl == 1'b0);
        if (r.press) presses_seen++;
      end
    end else if (ch == CHAR_NEWLINE) begin
      finish_line();
    end else if (ln_len < cfg_line_max) begin
      ln_len = ln_len + 8'd1;
      take_char(ch);
    end else begin
      // overflow: the byte is lost and the line so far is dropped
      clear_line();
    end
    if (hb_age > cfg_timeout) begin
      if (led != LED_IDLE) stale_drops++;
      led = LED_IDLE;
    end
    rgb     = LED_RGB[led];
    r.shown = led;
    r.red   = rgb[23:16];
    r.green = rgb[15:8];
    r.blue  = rgb[7:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_error(input string what);
    error_count++;
    if (error_count <= PRINT_LIMIT) $display("%0t ns: %s", $time, what);
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got %0d, expected %0d",
                             results_checked, name, got, want));
  endtask

  // Every result transfer is matched against the oldest prediction
  always @(posedge clk) begin : check_results
    led_report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_reports.size() == 0) begin
        report_error($sformatf("result transfer with nothing pending: %h", m_axis_tdata));
      end else begin
        want = pending_reports.pop_front();
        compare_field("press", 8'(m_axis_tdata[0]), 8'(want.press));
        compare_field("shown_state", 8'(m_axis_tdata[3:1]), 8'(want.shown));
        compare_field("led_red", m_axis_tdata[11:4], want.red);
        compare_field("led_green", m_axis_tdata[19:12], want.green);
        compare_field("led_blue", m_axis_tdata[27:20], want.blue);
        compare_field("padding", 8'(m_axis_tdata[31:28]), 8'd0);
        results_checked++;
      end
    end
  end

  // Receiver stalls about a quarter of the time, never while steady is set
  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 26);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status_led_command_controller_test: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // One input transfer; prediction is made at the accepting edge.
  // tvalid only drops inside an idle gap, so back-to-back items keep it high.
  task automatic send_item(input logic cmd, input logic lvl, input logic [7:0] ch);
    while (!steady && $urandom_range(0, 99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'd0, ch, lvl};
    do @(posedge clk); while (!s_axis_tready);
    pending_reports.push_back(predict_led(cmd, lvl, ch));
    items_sent++;
  endtask

  task automatic send_tick(input logic lvl);
    cur_level = lvl;
    send_item(CMD_TICK, lvl, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_byte(input logic [7:0] ch);
    send_item(CMD_BYTE, 1'($urandom_range(0, 1)), ch);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Stop sending and let every pending result come back, plus the pipeline depth
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // All three registers, back to back, only once the block has gone quiet
  task automatic set_config(input int deb, input int hb, input int maxlen);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_data  <= 16'(deb);
    @(posedge clk);
    cfg_index <= CFG_HEARTBEAT;
    cfg_data  <= 16'(hb);
    @(posedge clk);
    cfg_index <= CFG_MAX_LINE;
    cfg_data  <= 16'(maxlen);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_debounce = deb;
    cfg_timeout  = hb;
    cfg_line_max = maxlen;
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 4))
      0:       return CHAR_SPACE;
      1:       return 8'h09;
      2:       return 8'h0B;
      3:       return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset: registers at 35 / 5000 / 79, LED dim white
  task automatic test_reset_values();
    send_tick(1'b1);
    send_tick(1'b0);
    send_text("STATE ready\n");
    send_tick(1'b0);
  endtask

  task automatic test_debounce();
    // zero hold time: every stable change follows at once
    set_config(0, HEARTBEAT_RESET, MAX_LINE_RESET);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    // short hold with a bounce before the press
    set_config(3, HEARTBEAT_RESET, MAX_LINE_RESET);
    send_tick(1'b0);
    send_tick(1'b1);
    repeat (5) send_tick(1'b0);
    repeat (5) send_tick(1'b1);
    // longest hold: quiet count has to saturate before the press lands
    set_config(255, 65535, MAX_LINE_RESET);
    repeat (257) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic test_state_lines();
    set_config(DEBOUNCE_RESET, HEARTBEAT_RESET, MAX_LINE_RESET);
    send_text("STATE ready\n");
    // leading tab / VT / FF, trailing space and CR
    send_byte(8'h09);
    send_byte(8'h0B);
    send_byte(8'h0C);
    send_text("STATE recording ");
    send_byte(8'h0D);
    send_byte(CHAR_NEWLINE);
    send_text("STATE speaking\n");
    send_text("STATE error\n");
    send_text("STATE blink\n");        // unknown word, amber
    send_text("STATE\tready\n");       // tab after the prefix: not a state line
    send_text("STATE re ady\n");       // blank inside the rest: unknown
    send_text("STATE   \n");           // empty rest: ignored
    send_text("STATEready\nstate ready\n\n");
    send_text("STATE readyy\nSTATE read\n");
    send_text("STATE abcdefghijklmnopqrs\n"); // word position saturates
    send_text("STATE ");
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(CHAR_NEWLINE);
  endtask

  task automatic test_line_limit();
    set_config(DEBOUNCE_RESET, HEARTBEAT_RESET, 11);
    send_text("STATE ready\n");        // exactly at the limit
    send_text("STATE errorXSTATE speaking\n"); // first overflow drops the line
    send_text("STATE errorXSTATE ready\n");
    set_config(DEBOUNCE_RESET, HEARTBEAT_RESET, 1);
    send_text("STATE error\n");
    set_config(DEBOUNCE_RESET, HEARTBEAT_RESET, 255);
    send_text("   STATE recording   \n");
  endtask

  task automatic test_heartbeat();
    set_config(DEBOUNCE_RESET, 0, MAX_LINE_RESET);
    send_text("STATE error\n");
    send_byte("x");                    // bytes do not age the heartbeat
    send_tick(1'b1);                   // first tick is already past a zero timeout
    set_config(DEBOUNCE_RESET, 3, MAX_LINE_RESET);
    send_text("STATE ready\n");
    repeat (5) send_tick(1'b1);
    send_text("STATE speaking\n");
    send_tick(1'b0);
  endtask

  // A mostly well formed line with random damage
  task automatic random_line();
    logic [7:0] text [$];
    int rest_at;
    int k;
    logic [7:0] ch;
    repeat ($urandom_range(0, 2)) text.push_back(pick_blank());
    for (int p = 0; p < 5; p++) text.push_back(state_tag[p]);
    if ($urandom_range(0, 9) == 0)
      text[text.size() - 1 - $urandom_range(0, 4)] = 8'($urandom_range(0, 255));
    text.push_back(($urandom_range(0, 9) < 8) ? CHAR_SPACE : pick_blank());
    rest_at = text.size();
    k = $urandom_range(0, 5);
    if (k < 4) begin
      for (int i = 0; i < word_names[k].len(); i++) text.push_back(word_names[k][i]);
    end else if (k == 4) begin
      repeat ($urandom_range(1, 10)) text.push_back(8'($urandom_range(8'h61, 8'h7A)));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        ch = 8'($urandom_range(0, 255));
        text.push_back((ch == CHAR_NEWLINE) ? 8'h00 : ch);
      end
    end
    if ($urandom_range(0, 99) < 15)
      text[$urandom_range(rest_at, text.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0)
      text.insert($urandom_range(rest_at, text.size()), pick_blank());
    repeat ($urandom_range(0, 2)) text.push_back(pick_blank());
    if ($urandom_range(0, 99) < 95) text.push_back(CHAR_NEWLINE);
    foreach (text[i]) begin
      if ($urandom_range(0, 9) == 0) send_tick(cur_level);
      send_byte(text[i]);
    end
  endtask

  // Button run: mostly short, sometimes bouncing, sometimes long enough to settle
  task automatic random_button();
    logic lvl;
    int len;
    bit bouncy;
    lvl    = 1'($urandom_range(0, 1));
    len    = ($urandom_range(0, 3) == 0) ? cfg_debounce + $urandom_range(1, 3)
                                         : $urandom_range(1, 6);
    bouncy = ($urandom_range(0, 9) < 3);
    repeat (len) begin
      send_tick(lvl);
      if (bouncy) lvl = ~lvl;
    end
  endtask

  task automatic run_traffic(input int n, input int deb, input int hb, input int maxlen,
                             input bit no_idle);
    int start;
    int pick;
    set_config(deb, hb, maxlen);
    steady = no_idle;
    start  = items_sent;
    while (items_sent - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) random_line();
      else if (pick < 80) random_button();
      else repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end
    wait_idle();
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_traffic(40, DEBOUNCE_RESET, HEARTBEAT_RESET, MAX_LINE_RESET, 1'b0);
    run_traffic(30, 0, 0, 1, 1'b0);
    run_traffic(60, $urandom_range(1, 6), $urandom_range(8, 60), $urandom_range(12, 24),
                1'b1);
    run_traffic(20, 255, 65535, 255, 1'b0);
    run_traffic(40, $urandom_range(0, 8), $urandom_range(0, 300), $urandom_range(1, 255),
                1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_debounce();
    test_state_lines();
    test_line_limit();
    test_heartbeat();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk);
    $display("Covered %0d transfers, %0d results checked: %0d presses, %0d state lines,",
             items_sent, results_checked, presses_seen, state_lines);
    $display("%0d heartbeat fallbacks, %0d mismatches.", stale_drops, error_count);
    if (error_count == 0) begin
      $display("status_led_command_controller_test: clean");
    end else begin
      $display("status_led_command_controller_test: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/slcc_pkg.sv
rtl/core/slcc_line_parser.sv
rtl/core/status_led_command_controller.sv
rtl/core/slcc_checker.sv
sim/status_led_command_controller_test.sv
